### rtl/cws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cws_pkg
// Shared types and constants of the closest waypoint search core.
// ----------------------------------------------------------------------------
package cws_pkg;

   localparam int MAX_WAYPOINTS_DEFAULT = 1024;
   localparam int COORD_BITS_DEFAULT    = 24;

   // search radius register
   localparam int                     RADIUS_BITS  = 23;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 23'd2560000;
   localparam int                     RSQ_BITS     = 2 * RADIUS_BITS;

   // per-axis difference magnitude is saturated to 2^24
   localparam int                  DIFF_SAT_BITS = 24;
   localparam int                  MAG_BITS      = DIFF_SAT_BITS + 1;
   localparam logic [MAG_BITS-1:0] DIFF_SAT      = 25'h100_0000;
   localparam int                  SQ_BITS       = 2 * MAG_BITS;
   localparam int                  DIST_BITS     = SQ_BITS + 1;

   // result fields
   localparam int INDEX_BITS    = 10;
   localparam int RSP_DATA_BITS = 16;

   // register map
   localparam int         CSR_ADDR_BITS = 3;
   localparam int         CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_SEARCH_RADIUS = 1'b0;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

endpackage
`default_nettype wire

### rtl/cws_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cws_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cws_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/closest_waypoint_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// closest_waypoint_search_core
// Waypoint table in one RAM; a query scans it one entry per cycle through a
// read / difference / square / compare pipeline and returns the nearest entry.
// ----------------------------------------------------------------------------
// append and clear complete on acceptance and may follow back to back
// query: the single RAM read port streams one waypoint per cycle through the
//   four pipeline stages; with an empty table the scan ends at once
// the state returns to idle as the result is registered; then the next transaction is accepted
// reset: waypoint count cleared, search radius back to 10000 m; the waypoint
//   RAM is not cleared, entries are written before they are read
module closest_waypoint_search_core #(
   parameter int MAX_WAYPOINTS = cws_pkg::MAX_WAYPOINTS_DEFAULT,
   parameter int COORD_BITS    = cws_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,

   // tdata: pos_x, pos_y (then zero fill)
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: func
   input  wire logic [1:0]                        req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,

   // tdata: closest_index (then zero fill)
   output logic [cws_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // tuser: within_radius
   output logic [0:0]                             rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cws_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [cws_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [cws_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   localparam int AW    = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CW    = $clog2(MAX_WAYPOINTS + 1);
   localparam int EXTW  = (COORD_BITS + 1 > cws_pkg::MAG_BITS) ?
                          COORD_BITS + 1 : cws_pkg::MAG_BITS;
   localparam int MAG_W = cws_pkg::MAG_BITS;

   // magnitude of a - b, saturated to 2^24
   function automatic logic [MAG_W-1:0] abs_diff_sat(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b
   );
      logic [COORD_BITS:0] diff;
      logic [COORD_BITS:0] mag;
      logic [EXTW-1:0]     mag_ext;
      diff    = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      mag     = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
      mag_ext = EXTW'(mag);
      if (mag_ext > EXTW'(cws_pkg::DIFF_SAT)) begin
         return cws_pkg::DIFF_SAT;
      end
      return mag_ext[MAG_W-1:0];
   endfunction

   cws_pkg::state_type state_ff, state_in;
   cws_pkg::func_type  func;

   logic                              accept;
   logic                              start_s;
   logic                              issue_s;
   logic                              finish_s;
   logic                              scan_empty;

   logic [cws_pkg::RADIUS_BITS-1:0]   radius_ff;
   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     rd_cnt_ff;
   logic [COORD_BITS-1:0]             qx_ff, qy_ff;

   logic                              wr_en;
   logic [2*COORD_BITS-1:0]           ram_rd_data;

   logic                              v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]                     idx1_ff, idx2_ff, idx3_ff;
   logic [MAG_W-1:0]                  dx_ff, dy_ff;
   logic [cws_pkg::SQ_BITS-1:0]       sqx_ff, sqy_ff;
   logic [cws_pkg::DIST_BITS-1:0]     dist_sum;

   logic [cws_pkg::RSQ_BITS-1:0]      best_ff;
   logic [AW-1:0]                     best_idx_ff;
   logic                              found_ff;
   logic [AW+cws_pkg::INDEX_BITS-1:0] idx_wide;

   logic                              rsp_valid_ff;
   logic [cws_pkg::INDEX_BITS-1:0]    rsp_index_ff;
   logic                              rsp_found_ff;

   assign func   = cws_pkg::func_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= cws_pkg::RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == cws_pkg::REG_SEARCH_RADIUS) begin
         radius_ff <= csr_pwdata[cws_pkg::RADIUS_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == cws_pkg::REG_SEARCH_RADIUS) begin
         csr_prdata = cws_pkg::CSR_DATA_BITS'(radius_ff);
      end
   end

   // ---------------- state machine ----------------
   assign scan_empty = (rd_cnt_ff == count_ff) && !v1_ff && !v2_ff && !v3_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cws_pkg::ST_IDLE: begin
            if (accept && func == cws_pkg::FUNC_QUERY) begin
               state_in = cws_pkg::ST_SCAN;
            end
         end
         cws_pkg::ST_SCAN: begin
            if (scan_empty) begin
               state_in = cws_pkg::ST_DONE;
            end
         end
         cws_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = cws_pkg::ST_IDLE;
            end
         end
         default: state_in = cws_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue_s    = 1'b0;
      finish_s   = 1'b0;
      unique case (state_ff)
         cws_pkg::ST_IDLE: req_tready = 1'b1;
         cws_pkg::ST_SCAN: issue_s    = (rd_cnt_ff < count_ff);
         cws_pkg::ST_DONE: finish_s   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign start_s = accept && func == cws_pkg::FUNC_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- table fill ----------------
   assign wr_en = accept && func == cws_pkg::FUNC_APPEND &&
                  count_ff < CW'(MAX_WAYPOINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         unique case (func)
            cws_pkg::FUNC_APPEND: begin
               if (wr_en) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            cws_pkg::FUNC_CLEAR: count_ff <= '0;
            default: ;
         endcase
      end
   end

   cws_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_WAYPOINTS),
      .AW    (AW)
   ) u_waypoint_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata[2*COORD_BITS-1:0]),
      .rd_en   (issue_s),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // ---------------- scan pipeline ----------------
   always_ff @(posedge clock) begin
      if (start_s) begin
         qx_ff <= req_tdata[COORD_BITS-1:0];
         qy_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      if (start_s) begin
         rd_cnt_ff <= '0;
      end else if (issue_s) begin
         rd_cnt_ff <= rd_cnt_ff + 1'b1;
      end
      idx1_ff <= rd_cnt_ff[AW-1:0];
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= abs_diff_sat(qx_ff, ram_rd_data[COORD_BITS-1:0]);
      dy_ff   <= abs_diff_sat(qy_ff, ram_rd_data[2*COORD_BITS-1:COORD_BITS]);
      sqx_ff  <= cws_pkg::SQ_BITS'(dx_ff) * cws_pkg::SQ_BITS'(dx_ff);
      sqy_ff  <= cws_pkg::SQ_BITS'(dy_ff) * cws_pkg::SQ_BITS'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue_s;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start_s) begin
         best_ff     <= cws_pkg::RSQ_BITS'(radius_ff) * cws_pkg::RSQ_BITS'(radius_ff);
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (v3_ff && dist_sum < cws_pkg::DIST_BITS'(best_ff)) begin
         best_ff     <= dist_sum[cws_pkg::RSQ_BITS-1:0];
         best_idx_ff <= idx3_ff;
         found_ff    <= 1'b1;
      end
   end

   // ---------------- result register ----------------
   assign idx_wide = {{cws_pkg::INDEX_BITS{1'b0}}, best_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_s) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish_s) begin
         rsp_index_ff <= idx_wide[cws_pkg::INDEX_BITS-1:0];
         rsp_found_ff <= found_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cws_pkg::RSP_DATA_BITS'(rsp_index_ff);
   assign rsp_tuser  = rsp_found_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_WAYPOINTS))
      else $error("waypoint count beyond table depth");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == cws_pkg::ST_IDLE |-> !v1_ff && !v2_ff && !v3_ff)
      else $error("scan pipeline active outside a query");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish_s |=> rsp_valid_ff && state_ff == cws_pkg::ST_IDLE)
      else $error("finished query did not reach the result register");

   a_found_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff != cws_pkg::ST_IDLE && found_ff |-> CW'(best_idx_ff) < count_ff)
      else $error("chosen index outside stored waypoints");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      v1_ff || v2_ff || v3_ff |-> !wr_en)
      else $error("table written during a scan");

endmodule
`default_nettype wire
